// ===== rtl/facs_pkg.sv =====
package facs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_NORM,
    ST_DNORM,
    ST_DIV,
    ST_DRND,
    ST_FINISH
  } facs_state_e;

  localparam logic [31:0] F_EXP_MASK  = 32'h7f80_0000;
  localparam logic [31:0] F_MAN_MASK  = 32'h007f_ffff;
  localparam logic [31:0] F_MAG_MASK  = 32'h7fff_ffff;
  localparam logic [31:0] F_SIGN_MASK = 32'h8000_0000;
  localparam logic [63:0] D_QNAN      = 64'h7ff8_0000_0000_0000;
  localparam logic [63:0] D_INF       = 64'h7ff0_0000_0000_0000;

  // quotient bits: 53 mantissa bits and a guard bit
  localparam int unsigned DIV_STEPS = 54;

  typedef struct packed {
    logic [31:0] act_word;
    logic [31:0] exp_word;
    logic        last_item;
  } facs_in_t;

  typedef struct packed {
    logic [31:0] length;
    logic        all_equal;
    logic [31:0] diff_count;
    logic [31:0] first_diff_index;
    logic [31:0] first_actual_word;
    logic [31:0] first_expected_word;
    logic [63:0] max_abs_diff_bits;
    logic [63:0] max_rel_diff_bits;
    logic [31:0] max_ulp_gap;
    logic        abs_defined;
    logic        rel_defined;
    logic        ulp_defined;
  } facs_out_t;

  function automatic logic [31:0] order_key(input logic [31:0] w);
    return ((w & F_SIGN_MASK) != 32'd0) ? ~w : (w | F_SIGN_MASK);
  endfunction

  function automatic logic is_nan32(input logic [31:0] w);
    return ((w & F_EXP_MASK) == F_EXP_MASK) && ((w & F_MAN_MASK) != 32'd0);
  endfunction

  function automatic logic is_inf32(input logic [31:0] w);
    return (w & F_MAG_MASK) == F_EXP_MASK;
  endfunction

endpackage

// ===== rtl/facs_if.sv =====
interface facs_in_if import facs_pkg::*; ();
  logic     valid;
  logic     ready;
  facs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface facs_out_if import facs_pkg::*; ();
  logic      valid;
  logic      ready;
  facs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/float_array_compare_stats.sv =====
// Running comparison of two binary32 streams.
// in_i carries one (actual, expected, last_item) word per pair; out_o carries
// one summary word after each pair marked last_item, then the statistics
// start over for the next array.
// Path per pair: a bit-identical pair or a NaN/infinity pair goes from the
// prepare step straight to finish; +0 against -0 stops in the normalize
// step on a zero difference; any other differing pair normalizes the
// binary64 difference one bit a cycle, normalizes a subnormal divisor,
// runs the restoring divider loop and rounds the quotient, then finishes.
// The summary word is valid from the cycle in which the block is ready for
// the next pair and sits in the output register until taken. A new pair is
// accepted while it waits; only the next summary holds back until the
// register is free.
// Reset (rst_ni low, asynchronous) drops any pending summary and returns all
// statistics to their start values: index and counts zero, exact flag set,
// maxima zero and defined, no first mismatch.
module float_array_compare_stats import facs_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  facs_in_if.sink     in_i,
  facs_out_if.source  out_o
);

  facs_state_e state_q, state_d;

  // accepted pair
  logic [31:0] a_q, e_q;
  logic        last_q;

  // statistics
  logic [COUNT_BITS-1:0] item_q, mism_q, first_idx_q;
  logic        exact_q, have_first_q;
  logic [31:0] first_a_q, first_e_q;
  logic [63:0] abs_max_q, rel_max_q;
  logic [31:0] ulp_max_q;
  logic [2:0]  def_q;

  // datapath
  logic [63:0]        r_q;
  logic signed [11:0] sx_q, ea_q;
  logic [5:0]         k_q, cnt_q;
  logic [23:0]        dm_q;
  logic [54:0]        nm_q;
  logic [53:0]        qt_q;

  facs_out_t   out_q;
  logic        out_valid_q;

  // ---------------- pair classification and aligned add ----------------
  logic        a_nan, a_inf;
  logic [31:0] ka, ke, ulp;
  logic        swap;
  logic [31:0] xw, yw;
  logic [7:0]  ebx, eby, dsh;
  logic [23:0] mx, my;
  logic [63:0] bw, sw, sh, lost, sj, rsum;
  logic signed [11:0] sx_init;

  always_comb begin
    a_nan = is_nan32(a_q) || is_nan32(e_q);
    a_inf = is_inf32(a_q) || is_inf32(e_q);
    ka    = order_key(a_q);
    ke    = order_key(e_q);
    ulp   = (ka >= ke) ? (ka - ke) : (ke - ka);
    swap  = e_q[30:0] > a_q[30:0];
    xw    = swap ? e_q : a_q;
    yw    = swap ? a_q : e_q;
    ebx   = (xw[30:23] == 8'd0) ? 8'd1 : xw[30:23];
    eby   = (yw[30:23] == 8'd0) ? 8'd1 : yw[30:23];
    dsh   = ebx - eby;
    mx    = {xw[30:23] != 8'd0, xw[22:0]};
    my    = {yw[30:23] != 8'd0, yw[22:0]};
    bw    = {1'b0, mx, 39'd0};
    sw    = {1'b0, my, 39'd0};
    sh    = sw >> dsh[5:0];
    lost  = sw << (7'd64 - {1'b0, dsh[5:0]});
    if (dsh >= 8'd64) begin
      sj = {63'd0, my != 24'd0};
    end else begin
      sj = sh | {63'd0, lost != 64'd0};
    end
    rsum    = (xw[31] ^ yw[31]) ? (bw + sj) : (bw - sj);
    sx_init = $signed({4'd0, ebx}) - 12'sd150;
  end

  // ---------------- rounding of the difference ----------------
  logic        ad_up, ad_ovf;
  logic [53:0] ad_m;
  logic signed [11:0] ea_new;
  logic [63:0] ad_bits;
  logic [52:0] n_mant;

  always_comb begin
    ad_up   = r_q[10] & ((r_q[9:0] != 10'd0) | r_q[11]);
    ad_m    = {1'b0, r_q[63:11]} + {53'd0, ad_up};
    ad_ovf  = ad_m[53];
    ea_new  = sx_q + 12'sd24 - $signed({6'd0, k_q}) + $signed({11'd0, ad_ovf});
    ad_bits = {1'b0, 11'(ea_new + 12'sd1023), ad_ovf ? 52'd0 : ad_m[51:0]};
    n_mant  = ad_ovf ? {1'b1, 52'd0} : ad_m[52:0];
  end

  // ---------------- divider ----------------
  logic [52:0]        md;
  logic signed [11:0] ed;
  logic               div_ge;
  logic [54:0]        div_rem;
  logic               rd_up, rd_ovf;
  logic [53:0]        rd_m;
  logic [63:0]        rd_bits;

  always_comb begin
    md      = {dm_q, 29'd0};
    ed      = sx_q + 12'sd23;
    div_ge  = nm_q >= {2'd0, md};
    div_rem = div_ge ? (nm_q - {2'd0, md}) : nm_q;
    rd_up   = qt_q[0] & ((nm_q != 55'd0) | qt_q[1]);
    rd_m    = {1'b0, qt_q[53:1]} + {53'd0, rd_up};
    rd_ovf  = rd_m[53];
    rd_bits = {1'b0, 11'(ea_q + $signed({11'd0, rd_ovf}) + 12'sd1023),
               rd_ovf ? 52'd0 : rd_m[51:0]};
  end

  // ---------------- sequencer ----------------
  logic [COUNT_BITS-1:0] item_next;
  logic out_free;
  logic emit;

  assign item_next = item_q + 1'b1;
  assign out_free  = !out_valid_q || out_o.ready;
  assign emit      = (state_q == ST_FINISH) && last_q && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (a_q == e_q || a_nan || a_inf) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (r_q == 64'd0) begin
          state_d = ST_FINISH;
        end else if (r_q[63]) begin
          state_d = ST_DNORM;
        end
      end
      ST_DNORM: begin
        if (dm_q[23]) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = ST_DRND;
        end
      end
      ST_DRND: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!last_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // statistics and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q       <= '0;
      mism_q       <= '0;
      first_idx_q  <= '1;
      exact_q      <= 1'b1;
      have_first_q <= 1'b0;
      first_a_q    <= '0;
      first_e_q    <= '0;
      abs_max_q    <= '0;
      rel_max_q    <= '0;
      ulp_max_q    <= '0;
      def_q        <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_PREP: begin
          if (a_q != e_q) begin
            exact_q <= 1'b0;
            mism_q  <= mism_q + 1'b1;
            if (!have_first_q) begin
              have_first_q <= 1'b1;
              first_idx_q  <= item_q;
              first_a_q    <= a_q;
              first_e_q    <= e_q;
            end
            if (a_nan) begin
              def_q <= '0;
            end else if (a_inf) begin
              abs_max_q <= D_INF;
              def_q[2:1] <= 2'b00;
            end else if (def_q[2] && ulp > ulp_max_q) begin
              ulp_max_q <= ulp;
            end
          end
        end
        ST_NORM: begin
          if (r_q[63] && def_q[0] && ad_bits > abs_max_q) begin
            abs_max_q <= ad_bits;
          end
        end
        ST_DRND: begin
          if (def_q[1] && rd_bits > rel_max_q) begin
            rel_max_q <= rd_bits;
          end
        end
        ST_FINISH: begin
          if (!last_q) begin
            item_q <= item_next;
          end else if (out_free) begin
            item_q       <= '0;
            mism_q       <= '0;
            first_idx_q  <= '1;
            exact_q      <= 1'b1;
            have_first_q <= 1'b0;
            first_a_q    <= '0;
            first_e_q    <= '0;
            abs_max_q    <= '0;
            rel_max_q    <= '0;
            ulp_max_q    <= '0;
            def_q        <= '1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers and summary payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          a_q    <= in_i.data.act_word;
          e_q    <= in_i.data.exp_word;
          last_q <= in_i.data.last_item;
        end
      end
      ST_PREP: begin
        r_q  <= rsum;
        sx_q <= sx_init;
        dm_q <= mx;
        k_q  <= '0;
      end
      ST_NORM: begin
        if (!r_q[63]) begin
          r_q <= r_q << 1;
          k_q <= k_q + 1'b1;
        end else begin
          nm_q <= {2'd0, n_mant};
          ea_q <= ea_new;
        end
      end
      ST_DNORM: begin
        if (!dm_q[23]) begin
          dm_q <= dm_q << 1;
          sx_q <= sx_q - 12'sd1;
        end else begin
          // pre-scale so the quotient lands in [1, 2)
          if (nm_q < {2'd0, md}) begin
            nm_q <= nm_q << 1;
            ea_q <= ea_q - ed - 12'sd1;
          end else begin
            ea_q <= ea_q - ed;
          end
          cnt_q <= '0;
          qt_q  <= '0;
        end
      end
      ST_DIV: begin
        nm_q  <= div_rem << 1;
        qt_q  <= {qt_q[52:0], div_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_FINISH: begin
        if (last_q && out_free) begin
          out_q.length              <= 32'(item_next);
          out_q.all_equal           <= exact_q;
          out_q.diff_count          <= 32'(mism_q);
          out_q.first_diff_index    <= have_first_q ? 32'(first_idx_q) : '1;
          out_q.first_actual_word   <= have_first_q ? first_a_q : '0;
          out_q.first_expected_word <= have_first_q ? first_e_q : '0;
          out_q.max_abs_diff_bits   <= def_q[0] ? abs_max_q : D_QNAN;
          out_q.max_rel_diff_bits   <= def_q[1] ? rel_max_q : D_QNAN;
          out_q.max_ulp_gap         <= def_q[2] ? ulp_max_q : '1;
          out_q.abs_defined         <= def_q[0];
          out_q.rel_defined         <= def_q[1];
          out_q.ulp_defined         <= def_q[2];
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
